### hw/rtl/bal_pkg.sv
// Shared types and constants for the bounded array list engine.
// Holds the operation codes, the cell command set and the default capacity.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

	// Default number of list entries.
	localparam int CAPACITY = 16;

	// Field widths of the request and response words.
	localparam int OP_W    = 3;
	localparam int POS_W   = 6;
	localparam int VALUE_W = 32;
	localparam int IDX_W   = 5;
	localparam int COUNT_W = 5;

	// Operation codes carried in a request word.
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_READ   = 3'd3,
		OP_SEARCH = 3'd4,
		OP_SORT   = 3'd5
	} op_t;

	// What one storage cell does in a cycle.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_TAKE_LEFT,
		CELL_TAKE_RIGHT,
		CELL_PAIR_LO,
		CELL_PAIR_HI
	} cell_op_t;

	// Command bundle sent from the controller to each cell.
	typedef struct packed {
		cell_op_t op;
		logic     descending;
	} cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/bal_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on bal_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bal_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [bal_pkg::OP_W-1:0]              operation;
	logic signed [bal_pkg::POS_W-1:0]      position;
	logic signed [bal_pkg::VALUE_W-1:0]    item_value;
	logic                                  descending;

	modport source (output valid, operation, position, item_value, descending, input ready);
	modport sink (input valid, operation, position, item_value, descending, output ready);
endinterface

interface bal_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  ok;
	logic signed [bal_pkg::VALUE_W-1:0]    read_data;
	logic signed [bal_pkg::IDX_W-1:0]      found_at;
	logic [bal_pkg::COUNT_W-1:0]           count;

	modport source (output valid, ok, read_data, found_at, count, input ready);
	modport sink (input valid, ok, read_data, found_at, count, output ready);
endinterface

`default_nettype wire

### hw/rtl/bal_cell.sv
// One storage cell of the list chain: holds one entry and trades it with its neighbors.
// Depends on bal_pkg for the cell command type.
`timescale 1ns / 1ps
`default_nettype none

module bal_cell (
	input  wire                                  clk,
	input  wire bal_pkg::cell_ctl_t              ctl,
	input  wire logic signed [bal_pkg::VALUE_W-1:0] new_value,
	input  wire logic signed [bal_pkg::VALUE_W-1:0] left_entry,
	input  wire logic signed [bal_pkg::VALUE_W-1:0] right_entry,
	input  wire logic signed [bal_pkg::VALUE_W-1:0] key,
	output logic signed [bal_pkg::VALUE_W-1:0]   entry,
	output logic                                 match
);

	logic signed [bal_pkg::VALUE_W-1:0] entry_q;
	logic                               lo_swap;
	logic                               hi_swap;

	// Compare-exchange decisions for either side of a neighbor pair.
	always_comb begin
		lo_swap = ctl.descending ? (entry_q < right_entry) : (entry_q > right_entry);
		hi_swap = ctl.descending ? (left_entry < entry_q) : (left_entry > entry_q);
	end

	// Entry register; its content is undefined until first written.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			bal_pkg::CELL_HOLD:       entry_q <= entry_q;
			bal_pkg::CELL_LOAD:       entry_q <= new_value;
			bal_pkg::CELL_TAKE_LEFT:  entry_q <= left_entry;
			bal_pkg::CELL_TAKE_RIGHT: entry_q <= right_entry;
			bal_pkg::CELL_PAIR_LO:    entry_q <= lo_swap ? right_entry : entry_q;
			bal_pkg::CELL_PAIR_HI:    entry_q <= hi_swap ? left_entry : entry_q;
			default:                  entry_q <= entry_q;
		endcase
	end

	assign entry = entry_q;
	assign match = (entry_q == key);

endmodule

`default_nettype wire

### hw/rtl/bounded_array_list_engine.sv
// Top level of the bounded array list engine: controller, result register and cell chain.
// Depends on bal_pkg, bal_req_if, bal_rsp_if and bal_cell.
`timescale 1ns / 1ps
`default_nettype none

// The engine keeps an ordered list of up to CAPACITY signed 32-bit entries in a row
// of cells, one entry per cell. Each request word asks for append, insert (a negative
// position counts back from the end), remove, read, search or sort, and yields exactly
// one response word that also carries the length after the operation. Append, insert,
// remove, read and search latch the request, then, once the output register is free,
// every cell shifts, loads or compares in parallel. Sort runs odd-even transposition
// over the chain, one round per cycle. One word is worked on at a time; a finished
// response waits in its own output register, so the next request is taken while it
// is still unread. Entries are not cleared at reset and there is no clearing pass;
// only held entries are ever read.
module bounded_array_list_engine #(
	parameter int CAPACITY = bal_pkg::CAPACITY
) (
	input wire         clk,
	input wire         arst_n,
	bal_req_if.sink    req,
	bal_rsp_if.source  rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int PW = ((CW > bal_pkg::POS_W) ? CW : bal_pkg::POS_W) + 2;
	localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_SORT = 3'b100
	} state_t;

	state_t st_q;

	// Latched request word.
	bal_pkg::op_t                          op_q;
	logic signed [bal_pkg::POS_W-1:0]      position_q;
	logic signed [bal_pkg::VALUE_W-1:0]    item_value_q;
	logic                                  descending_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic [CW-1:0] round_q;

	// Response register.
	logic                                  res_valid_q;
	logic                                  res_ok_q;
	logic signed [bal_pkg::VALUE_W-1:0]    res_read_data_q;
	logic signed [bal_pkg::IDX_W-1:0]      res_found_at_q;
	logic [bal_pkg::COUNT_W-1:0]           res_count_q;

	logic slot_free;
	logic accept;
	logic res_load;
	logic sort_run;
	logic phase;

	logic signed [PW-1:0] pos_ext;
	logic signed [PW-1:0] count_ext;
	logic signed [PW-1:0] ins_idx;
	logic app_ok;
	logic ins_ok;
	logic rem_ok;
	logic op_ok;

	logic signed [bal_pkg::VALUE_W-1:0] cell_entry [CAPACITY];
	logic [CAPACITY-1:0]                cell_match;
	logic [CAPACITY-1:0]                cell_hit;
	bal_pkg::cell_ctl_t                 cell_ctl [CAPACITY];

	logic signed [bal_pkg::VALUE_W-1:0] rd_value;
	logic                               found_hit;
	logic [IW-1:0]                      found_idx;
	logic signed [bal_pkg::IDX_W-1:0]   found_at;

	// Handshake and sequencing terms.
	assign slot_free = !res_valid_q || rsp.ready;
	assign req.ready = (st_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign sort_run  = (st_q == ST_SORT) && (round_q < count_q);
	assign phase     = round_q[0];
	assign res_load  = slot_free &&
		((st_q == ST_EXEC) || ((st_q == ST_SORT) && !sort_run));

	// Index arithmetic and range checks for the latched word.
	always_comb begin
		pos_ext   = PW'(position_q);
		count_ext = $signed(PW'(count_q));
		ins_idx   = (pos_ext < 0) ? (count_ext + pos_ext) : pos_ext;
		app_ok    = (count_q < CAP_COUNT);
		ins_ok    = app_ok && (ins_idx >= 0) && (ins_idx <= count_ext);
		rem_ok    = (pos_ext >= 0) && (pos_ext < count_ext);
	end

	// Outcome and new length of the operation.
	always_comb begin
		op_ok      = 1'b1;
		count_next = count_q;
		unique case (op_q)
			bal_pkg::OP_APPEND: begin
				op_ok      = app_ok;
				count_next = app_ok ? (count_q + 1'b1) : count_q;
			end
			bal_pkg::OP_INSERT: begin
				op_ok      = ins_ok;
				count_next = ins_ok ? (count_q + 1'b1) : count_q;
			end
			bal_pkg::OP_REMOVE: begin
				op_ok      = rem_ok;
				count_next = rem_ok ? (count_q - 1'b1) : count_q;
			end
			bal_pkg::OP_READ,
			bal_pkg::OP_SEARCH,
			bal_pkg::OP_SORT: op_ok = 1'b1;
			default: op_ok = 1'b0;
		endcase
	end

	// The cell chain with its per-cell command decode.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic signed [PW-1:0] CELL_IDX = PW'(i);
		localparam logic CELL_ODD = 1'(i % 2);

		logic signed [bal_pkg::VALUE_W-1:0] left_in;
		logic signed [bal_pkg::VALUE_W-1:0] right_in;

		if (i == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_left
			assign left_in = cell_entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_in = '0;
		end else begin : g_right
			assign right_in = cell_entry[i+1];
		end

		always_comb begin
			cell_ctl[i].op         = bal_pkg::CELL_HOLD;
			cell_ctl[i].descending = descending_q;
			if ((st_q == ST_EXEC) && slot_free) begin
				unique case (op_q)
					bal_pkg::OP_APPEND: begin
						if (app_ok && (CELL_IDX == count_ext))
							cell_ctl[i].op = bal_pkg::CELL_LOAD;
					end
					bal_pkg::OP_INSERT: begin
						if (ins_ok && (CELL_IDX == ins_idx))
							cell_ctl[i].op = bal_pkg::CELL_LOAD;
						else if (ins_ok && (CELL_IDX > ins_idx))
							cell_ctl[i].op = bal_pkg::CELL_TAKE_LEFT;
					end
					bal_pkg::OP_REMOVE: begin
						if (rem_ok && (CELL_IDX >= pos_ext))
							cell_ctl[i].op = bal_pkg::CELL_TAKE_RIGHT;
					end
					default: cell_ctl[i].op = bal_pkg::CELL_HOLD;
				endcase
			end else if (sort_run) begin
				if ((CELL_ODD == phase) && ((CELL_IDX + 1) < count_ext))
					cell_ctl[i].op = bal_pkg::CELL_PAIR_LO;
				else if ((CELL_ODD != phase) && (CELL_IDX >= 1) && (CELL_IDX < count_ext))
					cell_ctl[i].op = bal_pkg::CELL_PAIR_HI;
			end
		end

		bal_cell u_cell (
			.clk         (clk),
			.ctl         (cell_ctl[i]),
			.new_value   (item_value_q),
			.left_entry  (left_in),
			.right_entry (right_in),
			.key         (item_value_q),
			.entry       (cell_entry[i]),
			.match       (cell_match[i])
		);

		// Read select: only the held cell at the requested position answers.
		assign cell_hit[i] = (CELL_IDX == pos_ext) && (CELL_IDX < count_ext);
	end

	// Read data gathered from the chain.
	always_comb begin
		rd_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_value = rd_value | (cell_hit[i] ? cell_entry[i] : '0);
		end
	end

	// First held cell that matches the search key.
	always_comb begin
		found_hit = 1'b0;
		found_idx = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i] && (CW'(i) < count_q)) begin
				found_hit = 1'b1;
				found_idx = IW'(i);
			end
		end
		found_at = found_hit ? $signed(bal_pkg::IDX_W'(found_idx)) : '1;
	end

	// Controller state, request latch, length and sort round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			count_q <= '0;
			round_q <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					round_q <= '0;
					if (accept)
						st_q <= (bal_pkg::op_t'(req.operation) == bal_pkg::OP_SORT) ?
							ST_SORT : ST_EXEC;
				end
				ST_EXEC: begin
					if (slot_free) begin
						count_q <= count_next;
						st_q    <= ST_IDLE;
					end
				end
				ST_SORT: begin
					if (sort_run)
						round_q <= round_q + 1'b1;
					else if (slot_free)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= bal_pkg::op_t'(req.operation);
			position_q   <= req.position;
			item_value_q <= req.item_value;
			descending_q <= req.descending;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_ok_q        <= op_ok;
			res_read_data_q <= (op_q == bal_pkg::OP_READ) ? rd_value : '0;
			res_found_at_q  <= (op_q == bal_pkg::OP_SEARCH) ? found_at : '1;
			res_count_q     <= bal_pkg::COUNT_W'(count_next);
		end
	end

	assign rsp.valid     = res_valid_q;
	assign rsp.ok        = res_ok_q;
	assign rsp.read_data = res_read_data_q;
	assign rsp.found_at  = res_found_at_q;
	assign rsp.count     = res_count_q;

	// The length never exceeds the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_COUNT)
		else $error("list length above capacity");

	// The length changes only in the cycle a response is loaded.
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!res_load |=> $stable(count_q))
		else $error("list length changed without a response");

	// A response is only produced while a word is being worked on.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (st_q != ST_IDLE))
		else $error("response loaded while idle");

	// An accepted word always leaves the idle state on the next edge.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (st_q != ST_IDLE))
		else $error("accepted word not taken up");

	// Sort rounds never outrun the list length.
	a_round_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SORT) |-> (round_q <= count_q))
		else $error("sort round count past list length");

endmodule

`default_nettype wire
